>>> hdl/uer_pkg.sv
package uer_pkg;

    localparam int COUNT_BITS = 17;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int PULSE_W = 16;
    localparam int DIST_W  = 14;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_TO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_TO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST  = 3'd7;

    localparam logic [7:0]         RST_SETTLE    = 8'd2;
    localparam logic [9:0]         RST_TRIGGER   = 10'd10;
    localparam logic [15:0]        RST_RISE_TO   = 16'd15000;
    localparam logic [15:0]        RST_FALL_TO   = 16'd35000;
    localparam logic [PULSE_W-1:0] RST_MIN_PULSE = 16'd116;
    localparam logic [PULSE_W-1:0] RST_MAX_PULSE = 16'd26200;
    localparam logic [DIST_W-1:0]  RST_MIN_DIST  = 14'd20;
    localparam logic [DIST_W-1:0]  RST_MAX_DIST  = 14'd4500;

    // distance = pulse * 343 / 2000, done as one multiply by a scaled reciprocal
    localparam int SPEED_NUM  = 343;
    localparam int SPEED_DEN  = 2000;
    localparam int DIST_SHIFT = 28;
    localparam longint unsigned DIST_MUL_L =
        ((longint'(SPEED_NUM) << DIST_SHIFT) + longint'(SPEED_DEN) - 1) / SPEED_DEN;
    localparam int DIST_MUL_W = 26;
    localparam logic [DIST_MUL_W-1:0] DIST_MUL = DIST_MUL_W'(DIST_MUL_L);
    localparam int PROD_W = PULSE_W + DIST_MUL_W;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_ECHO  = 3'd1,
        ST_TOO_LONG = 3'd2,
        ST_RANGE    = 3'd3,
        ST_INVALID  = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_SETTLE = 5'b00010,
        PH_TRIG   = 5'b00100,
        PH_RISE   = 5'b01000,
        PH_HIGH   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0]         settle;
        logic [9:0]         trigger;
        logic [15:0]        rise_to;
        logic [15:0]        fall_to;
        logic [PULSE_W-1:0] min_pulse;
        logic [PULSE_W-1:0] max_pulse;
        logic [DIST_W-1:0]  min_dist;
        logic [DIST_W-1:0]  max_dist;
    } t_cfg;

    typedef struct packed {
        logic [DIST_W-1:0]  dist_mm;
        logic [PULSE_W-1:0] pulse;
        t_status            status;
        logic               done;
        logic               busy;
        logic               trig;
    } t_result;

    localparam int OUT_PAD_W = OUT_TDATA_W - $bits(t_result);

endpackage

>>> hdl/uer_regs.sv
module uer_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [uer_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output uer_pkg::t_cfg                     o_cfg
);

    uer_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle    <= uer_pkg::RST_SETTLE;
            r_cfg.trigger   <= uer_pkg::RST_TRIGGER;
            r_cfg.rise_to   <= uer_pkg::RST_RISE_TO;
            r_cfg.fall_to   <= uer_pkg::RST_FALL_TO;
            r_cfg.min_pulse <= uer_pkg::RST_MIN_PULSE;
            r_cfg.max_pulse <= uer_pkg::RST_MAX_PULSE;
            r_cfg.min_dist  <= uer_pkg::RST_MIN_DIST;
            r_cfg.max_dist  <= uer_pkg::RST_MAX_DIST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                uer_pkg::CFG_SETTLE:    r_cfg.settle    <= i_cfg_data[7:0];
                uer_pkg::CFG_TRIGGER:   r_cfg.trigger   <= i_cfg_data[9:0];
                uer_pkg::CFG_RISE_TO:   r_cfg.rise_to   <= i_cfg_data[15:0];
                uer_pkg::CFG_FALL_TO:   r_cfg.fall_to   <= i_cfg_data[15:0];
                uer_pkg::CFG_MIN_PULSE: r_cfg.min_pulse <= i_cfg_data[uer_pkg::PULSE_W-1:0];
                uer_pkg::CFG_MAX_PULSE: r_cfg.max_pulse <= i_cfg_data[uer_pkg::PULSE_W-1:0];
                uer_pkg::CFG_MIN_DIST:  r_cfg.min_dist  <= i_cfg_data[uer_pkg::DIST_W-1:0];
                uer_pkg::CFG_MAX_DIST:  r_cfg.max_dist  <= i_cfg_data[uer_pkg::DIST_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/uer_judge.sv
module uer_judge (
    input  logic [uer_pkg::PULSE_W-1:0] i_pulse,
    input  uer_pkg::t_cfg               i_cfg,
    output uer_pkg::t_status            o_status,
    output logic [uer_pkg::DIST_W-1:0]  o_dist
);

    logic [uer_pkg::PROD_W-1:0] w_prod;
    logic [uer_pkg::DIST_W-1:0] w_dist;

    // reciprocal is exact for every 16-bit pulse at this shift
    assign w_prod = uer_pkg::PROD_W'(i_pulse) * uer_pkg::PROD_W'(uer_pkg::DIST_MUL);
    assign w_dist = w_prod[uer_pkg::DIST_SHIFT +: uer_pkg::DIST_W];

    always_comb begin
        if (i_pulse < i_cfg.min_pulse || i_pulse > i_cfg.max_pulse) begin
            o_status = uer_pkg::ST_INVALID;
            o_dist   = '0;
        end else if (w_dist < i_cfg.min_dist || w_dist > i_cfg.max_dist) begin
            o_status = uer_pkg::ST_RANGE;
            o_dist   = w_dist;
        end else begin
            o_status = uer_pkg::ST_OK;
            o_dist   = w_dist;
        end
    end

endmodule

>>> hdl/uer_step.sv
module uer_step #(
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_start,
    input  logic              i_echo,
    input  uer_pkg::t_cfg     i_cfg,
    output uer_pkg::t_result  o_res
);

    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    uer_pkg::t_phase                 r_phase, n_phase;
    logic [COUNT_BITS-1:0]           r_cnt, n_cnt;
    uer_pkg::t_status                r_last_status, n_status;
    logic [uer_pkg::PULSE_W-1:0]     r_last_pulse, n_pulse;
    logic [uer_pkg::DIST_W-1:0]      r_last_dist, n_dist;
    logic                            w_trig, w_done;
    uer_pkg::t_status                w_j_status;
    logic [uer_pkg::DIST_W-1:0]      w_j_dist;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic timed_out(input logic [COUNT_BITS-1:0] c,
                                       input logic [15:0] lim);
        return (CW'(c) > CW'(lim)) || (c == CNT_MAX);
    endfunction

    // pulse width is the held count on the tick the echo falls
    uer_judge u_judge (
        .i_pulse  (uer_pkg::PULSE_W'(r_cnt)),
        .i_cfg    (i_cfg),
        .o_status (w_j_status),
        .o_dist   (w_j_dist)
    );

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_status = r_last_status;
        n_pulse  = r_last_pulse;
        n_dist   = r_last_dist;
        w_trig   = 1'b0;
        w_done   = 1'b0;

        case (r_phase)
            uer_pkg::PH_SETTLE, uer_pkg::PH_TRIG, uer_pkg::PH_RISE, uer_pkg::PH_HIGH: ;
            default: n_phase = uer_pkg::PH_IDLE;
        endcase

        if (n_phase == uer_pkg::PH_IDLE && i_start) begin
            n_phase = uer_pkg::PH_SETTLE;
            n_cnt   = '0;
        end

        // settle may fall straight through into the trigger tick
        if (n_phase == uer_pkg::PH_SETTLE) begin
            if (CW'(n_cnt) >= CW'(i_cfg.settle)) begin
                n_phase = uer_pkg::PH_TRIG;
                n_cnt   = '0;
            end else begin
                n_cnt = sat_inc(n_cnt);
            end
        end

        if (n_phase == uer_pkg::PH_TRIG) begin
            w_trig = 1'b1;
            n_cnt  = sat_inc(n_cnt);
            if (CW'(n_cnt) >= CW'(i_cfg.trigger)) begin
                n_phase = uer_pkg::PH_RISE;
                n_cnt   = '0;
            end
        end else if (n_phase == uer_pkg::PH_RISE) begin
            if (i_echo) begin
                n_phase = uer_pkg::PH_HIGH;
                n_cnt   = COUNT_BITS'(1);
                if (timed_out(n_cnt, i_cfg.fall_to)) begin
                    n_status = uer_pkg::ST_TOO_LONG;
                    n_pulse  = '0;
                    n_dist   = '0;
                    n_phase  = uer_pkg::PH_IDLE;
                    n_cnt    = '0;
                    w_done   = 1'b1;
                end
            end else begin
                n_cnt = sat_inc(n_cnt);
                if (timed_out(n_cnt, i_cfg.rise_to)) begin
                    n_status = uer_pkg::ST_NO_ECHO;
                    n_pulse  = '0;
                    n_dist   = '0;
                    n_phase  = uer_pkg::PH_IDLE;
                    n_cnt    = '0;
                    w_done   = 1'b1;
                end
            end
        end else if (n_phase == uer_pkg::PH_HIGH) begin
            if (i_echo) begin
                n_cnt = sat_inc(n_cnt);
                if (timed_out(n_cnt, i_cfg.fall_to)) begin
                    n_status = uer_pkg::ST_TOO_LONG;
                    n_pulse  = '0;
                    n_dist   = '0;
                    n_phase  = uer_pkg::PH_IDLE;
                    n_cnt    = '0;
                    w_done   = 1'b1;
                end
            end else begin
                n_status = w_j_status;
                n_pulse  = uer_pkg::PULSE_W'(r_cnt);
                n_dist   = w_j_dist;
                n_phase  = uer_pkg::PH_IDLE;
                n_cnt    = '0;
                w_done   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= uer_pkg::PH_IDLE;
            r_cnt         <= '0;
            r_last_status <= uer_pkg::ST_OK;
            r_last_pulse  <= '0;
            r_last_dist   <= '0;
        end else if (i_adv) begin
            r_phase       <= n_phase;
            r_cnt         <= n_cnt;
            r_last_status <= n_status;
            r_last_pulse  <= n_pulse;
            r_last_dist   <= n_dist;
        end
    end

    assign o_res.trig    = w_trig;
    assign o_res.busy    = (n_phase != uer_pkg::PH_IDLE);
    assign o_res.done    = w_done;
    assign o_res.status  = n_status;
    assign o_res.pulse   = n_pulse;
    assign o_res.dist_mm = n_dist;

`ifndef NO_ASSERTIONS
    a_done_from_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && w_done) |-> (r_phase == uer_pkg::PH_RISE || r_phase == uer_pkg::PH_HIGH))
        else $error("done raised outside an echo wait");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && w_done) |=> (r_phase == uer_pkg::PH_IDLE && r_cnt == '0))
        else $error("finished measurement did not return to idle");

    a_trig_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && w_trig) |=> (r_phase == uer_pkg::PH_TRIG || r_phase == uer_pkg::PH_RISE))
        else $error("trigger driven high outside the trigger phase");

    a_hold_no_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> ($stable(r_phase) && $stable(r_cnt) && $stable(r_last_pulse)))
        else $error("state moved without a request");
`endif

endmodule

>>> hdl/ultrasonic_echo_ranger.sv
// Ultrasonic ranger: trigger / echo timing for a pulse-echo distance sensor.
// Input stream: one request per microsecond tick; tdata[0] start_request,
// tdata[1] echo_level. A start while idle holds the trigger low for the
// settle time, high for the trigger time, then times the echo pulse.
// Output stream: one result per request with the trigger level to drive,
// busy, a one-tick done flag and the status, pulse width and distance of
// the latest finished measurement.
// Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data at the
// clock edge; write only while no request is in flight.
// Data path: an accepted request is held in the input register and its
// result is loaded onto m_axis_tdata when the step advances.
// Throughput: one request per clock while m_axis_tready is high; the whole
// step of one tick (state update, the 16 x 26 distance multiply and the
// limit compares) sits between the input register and the result register.
// Stall: while m_axis_tready is low the result holds; one more request is
// taken into the input register, then s_axis_tready drops.
// Reset (i_rst_n low, synchronous): both streams empty, phase idle, latest
// status, pulse and distance zero, registers at their defaults.
module ultrasonic_echo_ranger #(
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] start_request, [1] echo_level, [7:2] zero
    input  logic [uer_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] trigger_level, [1] busy_res, [2] done_res, [5:3] status,
    // [21:6] pulse_ticks, [35:22] distance, [39:36] zero
    output logic [uer_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [uer_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic              r_in_valid;
    logic              r_in_start;
    logic              r_in_echo;
    logic              r_out_valid;
    uer_pkg::t_result  r_out_res;
    uer_pkg::t_result  w_res;
    uer_pkg::t_cfg     w_cfg;
    logic              w_adv;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    uer_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    uer_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_start (r_in_start),
        .i_echo  (r_in_echo),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_start <= s_axis_tdata[0];
            r_in_echo  <= s_axis_tdata[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{uer_pkg::OUT_PAD_W{1'b0}}, r_out_res.dist_mm, r_out_res.pulse,
                            r_out_res.status, r_out_res.done, r_out_res.busy,
                            r_out_res.trig};

endmodule
